FILE: sv/r2df_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2df_pkg
// shared constants, register indexes and the request descriptor for the
// raster 2d delta filter
// ----------------------------------------------------------------------------
package r2df_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    // column counter can hold MAX_WIDTH itself
    localparam int COL_W      = ADDR_W + 1;
    localparam int BYTE_W     = 8;
    localparam int ROW_W      = 13;
    localparam int COUNT_W    = 32;
    localparam int EXT_W      = COUNT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [EXT_W-1:0] MAX_WIDTH_EXT = EXT_W'(MAX_WIDTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION  = 2'd0,
        CFG_ROW_WIDTH  = 2'd1,
        CFG_BYTE_COUNT = 2'd2
    } t_cfg_index;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_dir;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_dir              dir;
        logic              filt;
        logic              above_zero;
        logic              left_zero;
        logic [ADDR_W-1:0] col;
        logic              last;
    } t_desc;

endpackage

FILE: sv/r2df_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2df_front
// configuration registers, row tracking and classification of each request
// ----------------------------------------------------------------------------
module r2df_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [r2df_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [r2df_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [r2df_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                i_fifo_full,
    output logic                                o_push,
    output r2df_pkg::t_desc                     o_desc
);

    r2df_pkg::t_dir                     r_dir;
    logic [r2df_pkg::ROW_W-1:0]         r_row_width;
    logic [r2df_pkg::COUNT_W-1:0]       r_byte_count;
    logic [r2df_pkg::COL_W-1:0]         r_col,         n_col;
    logic                               r_row_first,   n_row_first;
    logic                               r_row_full,    n_row_full;
    logic [r2df_pkg::COUNT_W-1:0]       r_bytes_taken, n_bytes_taken;

    logic                               accept;
    logic [r2df_pkg::EXT_W-1:0]         bt_ext, bc_ext, rw_ext;
    logic                               is_last, fit, col_zero, full_now, filt, row_end;
    logic [r2df_pkg::COL_W-1:0]         col_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_fifo_full;
    assign accept      = i_in_valid && !i_fifo_full;
    assign o_push      = accept;

    always_comb begin
        bt_ext   = {1'b0, r_bytes_taken};
        bc_ext   = {1'b0, r_byte_count};
        rw_ext   = r2df_pkg::EXT_W'(r_row_width);
        is_last  = (bt_ext + r2df_pkg::EXT_W'(1)) >= bc_ext;
        // a row is filtered only if it fits whole in what is left of the buffer
        fit      = (r_row_width != '0) && (rw_ext <= r2df_pkg::MAX_WIDTH_EXT) &&
                   ((bt_ext + rw_ext) <= bc_ext);
        col_zero = (r_col == '0);
        full_now = col_zero ? fit : r_row_full;
        filt     = full_now && (r_col < r2df_pkg::COL_W'(r2df_pkg::MAX_WIDTH));
        col_inc  = r_col + r2df_pkg::COL_W'(1);
        row_end  = r2df_pkg::EXT_W'(col_inc) >= rw_ext;
    end

    always_comb begin
        n_col         = r_col;
        n_row_first   = r_row_first;
        n_row_full    = r_row_full;
        n_bytes_taken = r_bytes_taken;
        if (accept) begin
            n_row_full    = full_now;
            n_bytes_taken = r_bytes_taken + r2df_pkg::COUNT_W'(1);
            if (filt) begin
                if (row_end) begin
                    n_col       = '0;
                    n_row_first = 1'b0;
                end else begin
                    n_col = col_inc;
                end
            end else begin
                n_col = '0;
            end
            // end of buffer starts a new one
            if (is_last) begin
                n_col         = '0;
                n_row_first   = 1'b1;
                n_row_full    = 1'b0;
                n_bytes_taken = '0;
            end
        end
    end

    always_comb begin
        o_desc.data       = i_data_byte;
        o_desc.dir        = r_dir;
        o_desc.filt       = filt;
        o_desc.above_zero = r_row_first;
        o_desc.left_zero  = col_zero;
        o_desc.col        = r_col[r2df_pkg::ADDR_W-1:0];
        o_desc.last       = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir         <= r2df_pkg::DIR_ENCODE;
            r_row_width   <= '0;
            r_byte_count  <= r2df_pkg::COUNT_W'(1);
            r_col         <= '0;
            r_row_first   <= 1'b1;
            r_row_full    <= 1'b0;
            r_bytes_taken <= '0;
        end else begin
            r_col         <= n_col;
            r_row_first   <= n_row_first;
            r_row_full    <= n_row_full;
            r_bytes_taken <= n_bytes_taken;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    r2df_pkg::CFG_DIRECTION: begin
                        r_dir <= r2df_pkg::t_dir'(i_cfg_data[0]);
                    end
                    r2df_pkg::CFG_ROW_WIDTH: begin
                        r_row_width <= i_cfg_data[r2df_pkg::ROW_W-1:0];
                    end
                    r2df_pkg::CFG_BYTE_COUNT: begin
                        r_byte_count <= i_cfg_data[r2df_pkg::COUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // mid-row columns only exist inside a row that was found to fit
    a_col_in_full_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col != '0) |-> r_row_full)
        else $error("column advanced outside a filtered row");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_last) |=> (r_bytes_taken == '0) && r_row_first && (r_col == '0))
        else $error("buffer state not restarted after last byte");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_fifo_full)
        else $error("request pushed into full queue");

endmodule

FILE: sv/r2df_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2df_fifo
// short queue of classified requests between the front and back parts
// ----------------------------------------------------------------------------
module r2df_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  r2df_pkg::t_desc i_desc,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output r2df_pkg::t_desc o_desc
);

    r2df_pkg::t_desc                r_mem [r2df_pkg::FIFO_DEPTH];
    logic [r2df_pkg::FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [r2df_pkg::FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [r2df_pkg::FIFO_CW-1:0]   r_count,  n_count;
    logic                           push_ok, pop_ok;

    assign o_full  = (r_count == r2df_pkg::FIFO_CW'(r2df_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + r2df_pkg::FIFO_AW'(1) : r_wr_ptr;
        n_rd_ptr = pop_ok  ? r_rd_ptr + r2df_pkg::FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + r2df_pkg::FIFO_CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - r2df_pkg::FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r2df_pkg::FIFO_CW'(r2df_pkg::FIFO_DEPTH))
        else $error("queue count out of range");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

FILE: sv/r2df_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2df_back
// line store read, delta arithmetic and the output register
// ----------------------------------------------------------------------------
module r2df_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fifo_valid,
    input  r2df_pkg::t_desc             i_desc,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [r2df_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_last_of_buffer
);

    logic [r2df_pkg::BYTE_W-1:0]    r_line [r2df_pkg::MAX_WIDTH];
    logic [r2df_pkg::BYTE_W-1:0]    r_rd_data;
    r2df_pkg::t_desc                r_b1;
    logic                           r_b1_valid;
    logic                           r_byp;
    logic [r2df_pkg::BYTE_W-1:0]    r_byp_data;
    logic [r2df_pkg::BYTE_W-1:0]    r_prev;
    logic                           r_out_valid;
    logic [r2df_pkg::BYTE_W-1:0]    r_out_byte;
    logic                           r_out_last;

    logic                           b1_adv, load, wr_en, byp_hit;
    logic [r2df_pkg::BYTE_W-1:0]    above, left, v_enc, res_enc, a_dec, res_dec;
    logic [r2df_pkg::BYTE_W-1:0]    wr_data, res, prev_next;

    assign b1_adv = r_b1_valid && (!r_out_valid || i_out_ready);
    assign load   = i_fifo_valid && (!r_b1_valid || b1_adv);
    assign o_pop  = load;
    assign wr_en  = b1_adv && r_b1.filt;
    // a write in the cycle of the read to the same entry is not seen by the read
    assign byp_hit = wr_en && (r_b1.col == i_desc.col);

    always_comb begin
        above   = r_b1.above_zero ? '0 : (r_byp ? r_byp_data : r_rd_data);
        left    = r_b1.left_zero ? '0 : r_prev;
        v_enc   = r_b1.data - above;
        res_enc = v_enc - left;
        a_dec   = r_b1.data + left;
        res_dec = a_dec + above;
        if (r_b1.dir == r2df_pkg::DIR_DECODE) begin
            wr_data   = a_dec;
            res       = res_dec;
            prev_next = r_b1.data;
        end else begin
            wr_data   = v_enc;
            res       = res_enc;
            prev_next = res_enc;
        end
        if (!r_b1.filt) begin
            res = r_b1.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rd_data <= r_line[i_desc.col];
        end
        if (wr_en) begin
            r_line[r_b1.col] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b1       <= i_desc;
            r_byp_data <= wr_data;
        end
        if (wr_en) begin
            r_prev <= prev_next;
        end
        if (b1_adv) begin
            r_out_byte <= res;
            r_out_last <= r_b1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_b1_valid <= 1'b1;
                r_byp      <= byp_hit;
            end else if (b1_adv) begin
                r_b1_valid <= 1'b0;
                r_byp      <= 1'b0;
            end
            if (b1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last_of_buffer = r_out_last;

    a_byp_needs_b1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> r_b1_valid)
        else $error("bypass flag set with empty stage");

    a_b1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b1_valid && !b1_adv) |=> $stable(r_b1) && $stable(r_rd_data) && $stable(r_byp))
        else $error("stage contents changed while stalled");

    a_no_write_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_b1_valid && r_b1.filt))
        else $error("line store written without a filtered request");

endmodule

FILE: sv/raster_2d_delta_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_2d_delta_filter_core
// two-dimensional byte delta filter, encode or decode, for a raster buffer
// ----------------------------------------------------------------------------
// usage:
//   config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   direction (index 0), row width (index 1) and byte count (index 2); write
//   only while no request is in flight.
//   input channel takes one data byte per request with valid / ready;
//   output channel gives the filtered byte and a last-of-buffer flag.
//   path: request queue, read stage, output register. throughput: one byte
//   per clock while the receiver is ready; the line store is one-read
//   one-write with a same-entry bypass, so nothing in the datapath stalls.
//   when the receiver stalls the result stays in the output register, the
//   four-entry request queue and the read stage keep filling, and input
//   ready drops once the queue is full.
//   reset clears the config to encode, width 0, byte count 1, and starts a
//   new buffer; line store contents are not cleared (the first row of each
//   buffer never reads it).
// ----------------------------------------------------------------------------
module raster_2d_delta_filter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [r2df_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [r2df_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [r2df_pkg::BYTE_W-1:0]         i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [r2df_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                                o_last_of_buffer
);

    logic            fifo_full, fifo_valid, push, pop;
    r2df_pkg::t_desc push_desc, head_desc;

    r2df_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    r2df_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .i_pop   (pop),
        .o_desc  (head_desc)
    );

    r2df_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fifo_valid     (fifo_valid),
        .i_desc           (head_desc),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_buffer (o_last_of_buffer)
    );

endmodule

FILE: sim/tb_raster_2d_delta_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raster_2d_delta_filter_core
// self-checking bench for the raster 2d delta filter: a byte queue feeds a
// valid/ready driver, each accepted request is run through a bit-exact
// filter predictor, and a monitor compares every result byte and last flag
// in order against the predicted stream
// ----------------------------------------------------------------------------
module tb_raster_2d_delta_filter_core;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 48;
    localparam int RANDOM_BYTES   = 480;
    localparam int STEADY_WIDTH   = 16;
    localparam int STEADY_BYTES   = 96;
    localparam logic [r2df_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // byte pattern used by the directed requests
    localparam logic [63:0] EDGE_BYTES = 64'h00FF_807F_01FE_55AA;

    typedef struct packed {
        logic [r2df_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_filt_byte;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [r2df_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [r2df_pkg::CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic [r2df_pkg::BYTE_W-1:0]       i_data_byte = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [r2df_pkg::BYTE_W-1:0]       o_out_byte;
    logic                              o_last_of_buffer;

    // predictor copy of the registers and the filter state
    r2df_pkg::t_dir                    cfg_dir   = r2df_pkg::DIR_ENCODE;
    logic [r2df_pkg::ROW_W-1:0]        cfg_width = '0;
    logic [r2df_pkg::COUNT_W-1:0]      cfg_count = 32'd1;
    logic [r2df_pkg::BYTE_W-1:0]       line_mem [r2df_pkg::MAX_WIDTH];
    logic [r2df_pkg::BYTE_W-1:0]       prev_byte = '0;
    int unsigned                       col       = 0;
    bit                                first_row = 1'b1;
    bit                                row_full  = 1'b0;
    logic [r2df_pkg::COUNT_W-1:0]      taken     = '0;

    logic [r2df_pkg::BYTE_W-1:0]       bytes_to_send [$];
    t_filt_byte                        expected_bytes [$];

    bit                                idle_on   = 1'b1;
    bit                                hold_arm  = 1'b0;
    bit                                hold_done = 1'b0;
    int                                hold_left = 0;
    int                                fails     = 0;
    int                                quiet_cycles = 0;

    raster_2d_delta_filter_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_buffer (o_last_of_buffer)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_filt_byte filter_byte(logic [r2df_pkg::BYTE_W-1:0] d);
        t_filt_byte                    r;
        logic [r2df_pkg::BYTE_W-1:0]   above;
        logic [r2df_pkg::BYTE_W-1:0]   left;
        logic [r2df_pkg::BYTE_W-1:0]   v;
        logic [r2df_pkg::ADDR_W-1:0]   idx;
        logic                          last;
        last   = ({1'b0, taken} + 33'd1) >= {1'b0, cfg_count};
        r.data = d;
        // row fit is decided once, at the first byte of each row
        if (col == 0)
            row_full = cfg_width != 0 && cfg_width <= r2df_pkg::MAX_WIDTH &&
                       ({1'b0, taken} + 33'(cfg_width)) <= {1'b0, cfg_count};
        if (row_full && col < r2df_pkg::MAX_WIDTH) begin
            idx   = r2df_pkg::ADDR_W'(col);
            above = first_row ? '0 : line_mem[idx];
            left  = (col == 0) ? '0 : prev_byte;
            if (cfg_dir == r2df_pkg::DIR_ENCODE) begin
                v             = d - above;
                line_mem[idx] = v;
                r.data        = v - left;
                prev_byte     = r.data;
            end else begin
                v             = d + left;
                line_mem[idx] = v;
                r.data        = v + above;
                prev_byte     = d;
            end
            // a width that shrank below the column ends the row here
            if (col + 1 >= cfg_width) begin
                col       = 0;
                first_row = 1'b0;
            end else begin
                col = col + 1;
            end
        end else begin
            col = 0;
        end
        taken = taken + 32'd1;
        if (last) begin
            prev_byte = '0;
            col       = 0;
            first_row = 1'b1;
            row_full  = 1'b0;
            taken     = '0;
        end
        r.last = last;
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_bytes.push_back(filter_byte(i_data_byte));
            if (!i_in_valid || o_in_ready) begin
                if (bytes_to_send.size() != 0 && !(idle_on && $urandom_range(99) < 33)) begin
                    i_in_valid  <= 1'b1;
                    i_data_byte <= bytes_to_send.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and result check
    always @(posedge i_clk) begin : result_check
        t_filt_byte want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got byte %h last %b",
                             $time, o_out_byte, o_last_of_buffer);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte expected %h got %h",
                                 $time, want.data, o_out_byte);
                        fails++;
                    end
                    if (o_last_of_buffer !== want.last) begin
                        $display("%0t: last_of_buffer expected %b got %b",
                                 $time, want.last, o_last_of_buffer);
                        fails++;
                    end
                end
            end
            // one long hold-off so the request queue fills and input ready drops
            if (hold_arm && !hold_done) begin
                hold_done   <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !idle_on || $urandom_range(99) >= 33;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // leaves the write valid high; caller drops it after the last write
    task automatic cfg_write(logic [r2df_pkg::CFG_IDX_W-1:0] idx,
                             logic [r2df_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            r2df_pkg::CFG_DIRECTION:  cfg_dir   = r2df_pkg::t_dir'(data[0]);
            r2df_pkg::CFG_ROW_WIDTH:  cfg_width = data[r2df_pkg::ROW_W-1:0];
            r2df_pkg::CFG_BYTE_COUNT: cfg_count = data;
            default: ;
        endcase
    endtask

    task automatic push_pattern(int first, int n);
        for (int k = 0; k < n; k++)
            bytes_to_send.push_back(EDGE_BYTES[8 * ((first + k) % 8) +: 8]);
    endtask

    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || i_in_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int n;
        int w;
        int phase;
        int total;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: width 0, count 1, every byte passes and is last
        push_pattern(0, 2);
        wait_idle();

        // encode, two full rows
        cfg_write(r2df_pkg::CFG_DIRECTION, 32'(r2df_pkg::DIR_ENCODE));
        cfg_write(r2df_pkg::CFG_ROW_WIDTH, 32'd2);
        cfg_write(r2df_pkg::CFG_BYTE_COUNT, 32'd4);
        i_cfg_valid <= 1'b0;
        push_pattern(0, 4);
        wait_idle();

        // decode, two full rows then a partial row that passes through
        cfg_write(r2df_pkg::CFG_DIRECTION, 32'(r2df_pkg::DIR_DECODE));
        cfg_write(r2df_pkg::CFG_ROW_WIDTH, 32'd3);
        cfg_write(r2df_pkg::CFG_BYTE_COUNT, 32'd8);
        i_cfg_valid <= 1'b0;
        push_pattern(1, 8);
        wait_idle();

        // width field all ones, above the line store size
        cfg_write(r2df_pkg::CFG_ROW_WIDTH, 32'hFFFF_FFFF);
        cfg_write(r2df_pkg::CFG_BYTE_COUNT, 32'd3);
        i_cfg_valid <= 1'b0;
        push_pattern(4, 3);
        wait_idle();

        // zero byte count flags every byte
        cfg_write(r2df_pkg::CFG_ROW_WIDTH, 32'd2);
        cfg_write(r2df_pkg::CFG_BYTE_COUNT, 32'd0);
        i_cfg_valid <= 1'b0;
        push_pattern(2, 2);
        wait_idle();

        // open-ended buffer, stop in the middle of the second row
        cfg_write(r2df_pkg::CFG_DIRECTION, 32'(r2df_pkg::DIR_ENCODE));
        cfg_write(r2df_pkg::CFG_ROW_WIDTH, 32'd4);
        cfg_write(r2df_pkg::CFG_BYTE_COUNT, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        push_pattern(0, 6);
        wait_idle();

        // mid-buffer: shrink width below the current column, flip direction
        cfg_write(r2df_pkg::CFG_ROW_WIDTH, 32'd1);
        cfg_write(r2df_pkg::CFG_DIRECTION, 32'(r2df_pkg::DIR_DECODE));
        cfg_write(CFG_SPARE, 32'd0);
        i_cfg_valid <= 1'b0;
        push_pattern(3, 3);
        wait_idle();

        // mid-buffer count drop closes the buffer on the next byte
        cfg_write(r2df_pkg::CFG_BYTE_COUNT, 32'd10);
        i_cfg_valid <= 1'b0;
        push_pattern(6, 1);
        wait_idle();

        // one buffer of several full rows, no idling on either side
        idle_on = 1'b0;
        cfg_write(r2df_pkg::CFG_DIRECTION, 32'(r2df_pkg::DIR_ENCODE));
        cfg_write(r2df_pkg::CFG_ROW_WIDTH, 32'(STEADY_WIDTH));
        cfg_write(r2df_pkg::CFG_BYTE_COUNT, 32'(STEADY_BYTES));
        i_cfg_valid <= 1'b0;
        repeat (STEADY_BYTES) bytes_to_send.push_back(8'($urandom_range(255)));
        wait_idle();
        idle_on = 1'b1;

        // random buffers; the width only changes between buffers, so rows
        // after the first only read entries written earlier in the buffer
        total = 0;
        phase = 0;
        while (total < RANDOM_BYTES) begin
            if (taken == '0 || $urandom_range(1) == 0) begin
                if ($urandom_range(1) == 0)
                    cfg_write(r2df_pkg::CFG_DIRECTION, $urandom());
                if (taken == '0 && $urandom_range(3) != 0) begin
                    case ($urandom_range(9))
                        0:       w = 0;
                        1:       w = int'($urandom_range(8191, r2df_pkg::MAX_WIDTH + 1));
                        2:       w = int'($urandom_range(64, 9));
                        3:       w = r2df_pkg::MAX_WIDTH;
                        default: w = int'($urandom_range(8, 1));
                    endcase
                    cfg_write(r2df_pkg::CFG_ROW_WIDTH, ($urandom() & ~32'h1FFF) | 32'(w));
                end
                case ($urandom_range(7))
                    0: cfg_write(r2df_pkg::CFG_BYTE_COUNT, '0);
                    1: cfg_write(r2df_pkg::CFG_BYTE_COUNT, '1);
                    2: cfg_write(r2df_pkg::CFG_BYTE_COUNT, $urandom());
                    default: begin
                        if (cfg_width != 0 && cfg_width <= 64)
                            cfg_write(r2df_pkg::CFG_BYTE_COUNT,
                                      cfg_width * $urandom_range(5, 1) + $urandom_range(3));
                        else
                            cfg_write(r2df_pkg::CFG_BYTE_COUNT, $urandom_range(40, 1));
                    end
                endcase
                if ($urandom_range(7) == 0)
                    cfg_write(CFG_SPARE, $urandom());
                i_cfg_valid <= 1'b0;
            end
            // mostly run the buffer to its end, otherwise stop somewhere inside
            if (cfg_count > taken && cfg_count - taken <= 200 && $urandom_range(4) != 0)
                n = int'(cfg_count - taken);
            else
                n = int'($urandom_range(40, 5));
            if (phase == 3) begin
                hold_arm = 1'b1;
                n        = 60;
            end
            repeat (n) bytes_to_send.push_back(8'($urandom_range(255)));
            total += n;
            phase++;
            wait_idle();
        end

        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
